@@ rtl/core/dsrle_pkg.sv @@
// ----------------------------------------------------------------------------
// dsrle_pkg: shared types and constants for the sector record rle decoder
// Request/response structs, internal step result, phase and error codes.
// ----------------------------------------------------------------------------
package dsrle_pkg;

    // decoded bytes can never exceed this, whatever the limit register says
    localparam logic [13:0] SECTOR_MAX   = 14'd8192;
    localparam logic [13:0] LIMIT_RESET  = 14'd8192;
    localparam logic [7:0]  FLAG_BOUND   = 8'd5;
    localparam logic [2:0]  KIND1_LOG    = 3'd1;

    localparam logic [7:0]  KIND_RAW     = 8'd0;
    localparam logic [7:0]  KIND_REPEAT  = 8'd1;
    localparam logic [7:0]  KIND_RUNS    = 8'd2;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_KIND     = 3'd1,
        ERR_FLAG     = 3'd2,
        ERR_OVERFLOW = 3'd3,
        ERR_LENGTH   = 3'd4
    } dsrle_err_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_LIT0  = 4'd1,
        PH_CLO   = 4'd2,
        PH_CHI   = 4'd3,
        PH_P0    = 4'd4,
        PH_P1    = 4'd5,
        PH_FLAG  = 4'd6,
        PH_COUNT = 4'd7,
        PH_RLIT  = 4'd8,
        PH_RPAT  = 4'd9
    } dsrle_phase_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  in_byte;
        logic        start_of_record;
        logic [15:0] record_length;
    } dsrle_req_t;

    typedef struct packed {
        logic        accepted;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [12:0] out_index;
        logic        record_done;
        logic [2:0]  error_code;
    } dsrle_rsp_t;

    // result of one step before the pattern memory data is merged in
    typedef struct packed {
        logic        accepted;
        logic        out_valid;
        logic        use_mem;
        logic [7:0]  lit_byte;
        logic [12:0] out_index;
        logic        record_done;
        dsrle_err_t  error_code;
    } dsrle_step_t;

endpackage

@@ rtl/core/disk_image_sector_rle_decoder.sv @@
// ----------------------------------------------------------------------------
// disk_image_sector_rle_decoder: sector record rle decoder
// Expands raw, repeat and run-encoded sector records into sector bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one request per cycle while
//   req_stall is low: mode 0 pushes an encoded byte, mode 1 pulls one byte of a
//   pending pattern expansion. Every request yields exactly one response on the
//   rsp channel (rsp_valid / rsp_stall / rsp).
//   The response is registered and appears in the cycle after the request is
//   taken. The pattern store is a one-port-write, registered-read memory,
//   read in the request cycle and merged with the output register's payload.
//   The output register is the only buffer: while rsp_stall holds a waiting
//   response, req_stall is raised and the response payload stays put; when
//   the response drains in the same cycle a new request is taken.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the per-record
//   byte limit; cfg_ready is always high. Write it only while idle.
//   Reset (rst_n low, asynchronous) returns the decoder to idle, clears the
//   output valid flag and sets the limit to 8192. The pattern store is not
//   cleared; it is always written before it is read.
// ----------------------------------------------------------------------------
module disk_image_sector_rle_decoder #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  dsrle_pkg::dsrle_req_t  req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output dsrle_pkg::dsrle_rsp_t  rsp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [13:0]            cfg_data
);
    import dsrle_pkg::*;

    localparam int AW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic          take;
    logic [13:0]   limit_reg;
    logic [13:0]   limit_eff;
    dsrle_step_t   step;
    dsrle_step_t   res_reg;
    logic          res_valid_reg, res_valid_next;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    assign cfg_ready = 1'b1;
    assign req_stall = res_valid_reg & rsp_stall;
    assign take      = req_valid & ~req_stall;
    assign limit_eff = (limit_reg > SECTOR_MAX) ? SECTOR_MAX : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    dsrle_ctrl #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
        .AW(AW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .take(take),
        .req(req),
        .limit(limit_eff),
        .step(step),
        .mem_we(mem_we),
        .mem_addr(mem_addr),
        .mem_wdata(mem_wdata)
    );

    dsrle_pattern_mem #(
        .DEPTH(MAX_PATTERN_BYTES),
        .AW(AW)
    ) u_pattern_mem (
        .clk(clk),
        .wr_en(take & mem_we),
        .rd_en(take),
        .addr(mem_addr),
        .wr_data(mem_wdata),
        .rd_data(mem_rdata)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg & rsp_stall;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= step;
        end
    end

    // memory read data holds with res_reg, since both load only on take
    assign rsp_valid       = res_valid_reg;
    assign rsp.accepted    = res_reg.accepted;
    assign rsp.out_valid   = res_reg.out_valid;
    assign rsp.out_byte    = res_reg.use_mem ? mem_rdata : res_reg.lit_byte;
    assign rsp.out_index   = res_reg.out_index;
    assign rsp.record_done = res_reg.record_done;
    assign rsp.error_code  = res_reg.error_code;

    a_take_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> rsp_valid)
        else $error("accepted request produced no response");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid)
        else $error("request stalled with empty output register");

    a_error_ends_record: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error_code != ERR_NONE |-> rsp.record_done && !rsp.out_valid)
        else $error("error response without record end or with data");

    a_pull_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        take && req.mode |=> !rsp.accepted)
        else $error("pull request marked accepted");

endmodule

@@ rtl/core/dsrle_pattern_mem.sv @@
// ----------------------------------------------------------------------------
// dsrle_pattern_mem: pattern byte store
// One shared address for write and read, read data registered.
// ----------------------------------------------------------------------------
module dsrle_pattern_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic          rd_en,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wr_data,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // every request reads; a push may also write the same address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/dsrle_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsrle_ctrl: record decoder state machine
// Walks the record headers and runs, drives the pattern memory and forms
// the step result for each request.
// ----------------------------------------------------------------------------
module dsrle_ctrl #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int AW                = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  dsrle_pkg::dsrle_req_t   req,
    input  logic [13:0]             limit,
    output dsrle_pkg::dsrle_step_t  step,
    output logic                    mem_we,
    output logic [AW-1:0]           mem_addr,
    output logic [7:0]              mem_wdata
);
    import dsrle_pkg::*;

    dsrle_phase_t  phase_reg, phase_next;
    logic          kind1_reg, kind1_next;
    logic [15:0]   record_len_reg, record_len_next;
    logic [15:0]   consumed_reg, consumed_next;
    logic [2:0]    run_flag_reg, run_flag_next;
    logic [15:0]   repeat_left_reg, repeat_left_next;
    logic [2:0]    pat_log_reg, pat_log_next;
    logic [AW-1:0] pat_pos_reg, pat_pos_next;
    logic [7:0]    literal_left_reg, literal_left_next;
    logic [13:0]   sector_pos_reg, sector_pos_next;
    logic          expanding_reg, expanding_next;

    logic [15:0]   consumed_inc;
    logic          emit_ok;
    logic          last_pos;
    logic          flag_ok;
    logic          do_emit;
    logic          do_run_end;
    logic          do_finish;
    dsrle_err_t    fin_err;

    assign consumed_inc = (consumed_reg == 16'hFFFF) ? consumed_reg : consumed_reg + 16'd1;
    assign emit_ok      = sector_pos_reg < limit;
    assign last_pos     = pat_pos_reg == AW'((32'd1 << pat_log_reg) - 32'd1);
    assign flag_ok      = (req.in_byte < FLAG_BOUND)
                          && ((32'd1 << req.in_byte[2:0]) <= 32'(MAX_PATTERN_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            kind1_reg        <= 1'b0;
            record_len_reg   <= '0;
            consumed_reg     <= '0;
            run_flag_reg     <= '0;
            repeat_left_reg  <= '0;
            pat_log_reg      <= '0;
            pat_pos_reg      <= '0;
            literal_left_reg <= '0;
            sector_pos_reg   <= '0;
            expanding_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg        <= phase_next;
            kind1_reg        <= kind1_next;
            record_len_reg   <= record_len_next;
            consumed_reg     <= consumed_next;
            run_flag_reg     <= run_flag_next;
            repeat_left_reg  <= repeat_left_next;
            pat_log_reg      <= pat_log_next;
            pat_pos_reg      <= pat_pos_next;
            literal_left_reg <= literal_left_next;
            sector_pos_reg   <= sector_pos_next;
            expanding_reg    <= expanding_next;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        kind1_next        = kind1_reg;
        record_len_next   = record_len_reg;
        consumed_next     = consumed_reg;
        run_flag_next     = run_flag_reg;
        repeat_left_next  = repeat_left_reg;
        pat_log_next      = pat_log_reg;
        pat_pos_next      = pat_pos_reg;
        literal_left_next = literal_left_reg;
        sector_pos_next   = sector_pos_reg;
        expanding_next    = expanding_reg;

        step       = '0;
        step.error_code = ERR_NONE;
        mem_we     = 1'b0;
        mem_addr   = pat_pos_reg;
        mem_wdata  = req.in_byte;
        do_emit    = 1'b0;
        do_run_end = 1'b0;
        do_finish  = 1'b0;
        fin_err    = ERR_NONE;

        if (req.mode)
        begin
            // pull: one byte of the pending pattern expansion
            if (expanding_reg)
            begin
                if (!emit_ok)
                begin
                    do_finish = 1'b1;
                    fin_err   = ERR_OVERFLOW;
                end
                else
                begin
                    do_emit      = 1'b1;
                    step.use_mem = 1'b1;
                    if (last_pos)
                    begin
                        pat_pos_next     = '0;
                        repeat_left_next = repeat_left_reg - 16'd1;
                        if (repeat_left_reg == 16'd1)
                        begin
                            expanding_next = 1'b0;
                            if (kind1_reg)
                            begin
                                do_finish = 1'b1;
                            end
                            else
                            begin
                                do_run_end = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        pat_pos_next = pat_pos_reg + AW'(1);
                    end
                end
            end
        end
        else if (!expanding_reg)
        begin
            step.accepted = 1'b1;
            if (req.start_of_record)
            begin
                sector_pos_next   = '0;
                record_len_next   = req.record_length;
                consumed_next     = 16'd1;
                repeat_left_next  = '0;
                literal_left_next = '0;
                pat_pos_next      = '0;
                pat_log_next      = '0;
                run_flag_next     = '0;
                if (req.record_length == 16'd0)
                begin
                    do_finish = 1'b1;
                    fin_err   = ERR_LENGTH;
                end
                else if (req.in_byte > KIND_RUNS)
                begin
                    do_finish = 1'b1;
                    fin_err   = ERR_KIND;
                end
                else
                begin
                    kind1_next = req.in_byte == KIND_REPEAT;
                    if (req.in_byte == KIND_REPEAT)
                    begin
                        phase_next = PH_CLO;
                    end
                    else if (req.record_length == 16'd1)
                    begin
                        do_finish = 1'b1;
                    end
                    else if (req.in_byte == KIND_RAW)
                    begin
                        phase_next = PH_LIT0;
                    end
                    else
                    begin
                        phase_next = PH_FLAG;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LIT0:
                    begin
                        consumed_next = consumed_inc;
                        if (!emit_ok)
                        begin
                            do_finish = 1'b1;
                            fin_err   = ERR_OVERFLOW;
                        end
                        else
                        begin
                            do_emit   = 1'b1;
                            do_finish = consumed_inc >= record_len_reg;
                        end
                    end
                    PH_CLO:
                    begin
                        consumed_next    = consumed_inc;
                        repeat_left_next = {8'd0, req.in_byte};
                        phase_next       = PH_CHI;
                    end
                    PH_CHI:
                    begin
                        consumed_next    = consumed_inc;
                        repeat_left_next = {req.in_byte, repeat_left_reg[7:0]};
                        phase_next       = PH_P0;
                    end
                    PH_P0:
                    begin
                        consumed_next = consumed_inc;
                        mem_we        = 1'b1;
                        mem_addr      = '0;
                        phase_next    = PH_P1;
                    end
                    PH_P1:
                    begin
                        consumed_next = consumed_inc;
                        mem_we        = 1'b1;
                        mem_addr      = AW'(1);
                        pat_log_next  = KIND1_LOG;
                        pat_pos_next  = '0;
                        if (repeat_left_reg == 16'd0)
                        begin
                            do_finish = 1'b1;
                        end
                        else
                        begin
                            expanding_next = 1'b1;
                        end
                    end
                    PH_FLAG:
                    begin
                        consumed_next = consumed_inc;
                        if (!flag_ok)
                        begin
                            do_finish = 1'b1;
                            fin_err   = ERR_FLAG;
                        end
                        else
                        begin
                            run_flag_next = req.in_byte[2:0];
                            phase_next    = PH_COUNT;
                        end
                    end
                    PH_COUNT:
                    begin
                        consumed_next = consumed_inc;
                        if (run_flag_reg == 3'd0)
                        begin
                            literal_left_next = req.in_byte;
                            if (req.in_byte == 8'd0)
                            begin
                                do_run_end = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_RLIT;
                            end
                        end
                        else
                        begin
                            pat_log_next     = run_flag_reg;
                            pat_pos_next     = '0;
                            repeat_left_next = {8'd0, req.in_byte};
                            phase_next       = PH_RPAT;
                        end
                    end
                    PH_RLIT:
                    begin
                        consumed_next = consumed_inc;
                        if (!emit_ok)
                        begin
                            do_finish = 1'b1;
                            fin_err   = ERR_OVERFLOW;
                        end
                        else
                        begin
                            do_emit           = 1'b1;
                            literal_left_next = literal_left_reg - 8'd1;
                            do_run_end        = literal_left_reg == 8'd1;
                        end
                    end
                    PH_RPAT:
                    begin
                        consumed_next = consumed_inc;
                        mem_we        = 1'b1;
                        if (last_pos)
                        begin
                            pat_pos_next = '0;
                            if (repeat_left_reg == 16'd0)
                            begin
                                do_run_end = 1'b1;
                            end
                            else
                            begin
                                expanding_next = 1'b1;
                            end
                        end
                        else
                        begin
                            pat_pos_next = pat_pos_reg + AW'(1);
                        end
                    end
                    default:
                    begin
                        // idle without a record start: byte is dropped
                    end
                endcase
            end
        end

        if (do_emit)
        begin
            step.out_valid  = 1'b1;
            step.lit_byte   = step.use_mem ? 8'd0 : req.in_byte;
            step.out_index  = sector_pos_reg[12:0];
            sector_pos_next = sector_pos_reg + 14'd1;
        end

        // end of a run: record ends once the consumed bytes reach its length
        if (do_run_end)
        begin
            if (consumed_next >= record_len_reg)
            begin
                do_finish = 1'b1;
            end
            else
            begin
                phase_next = PH_FLAG;
            end
        end

        if (do_finish)
        begin
            step.record_done = 1'b1;
            step.error_code  = fin_err;
            phase_next       = PH_IDLE;
            expanding_next   = 1'b0;
        end
    end

endmodule
